[sv/lcfd_pkg.sv]
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the frame deframer.
package lcfd_pkg;

  localparam int LEN_W = 9;
  localparam int CRC_W = 16;
  localparam int IDLE_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [LEN_W-1:0] MAX_LEN_LIMIT = 9'd256;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 9'd256;
  localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RESET = 16'd20;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_IDLE_TIMEOUT = 1'b1;

  // input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result status codes
  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_CRC_GOOD = 2'd1;
  localparam logic [1:0] ST_CRC_BAD = 2'd2;
  localparam logic [1:0] ST_ABORT = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [1:0]       status;
    logic             frame_end;
    logic [LEN_W-1:0] frame_length;
  } result_t;

  // MSB-first CRC over one byte, eight shift steps unrolled
  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[sv/lcfd_in_stage.sv]
// Input register stage: holds one accepted item until the core takes it.
module lcfd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  input  logic              s_tuser,   // [0] kind
  input  logic              advance,
  output logic              item_valid,
  output lcfd_pkg::in_item_t item
);
  import lcfd_pkg::*;

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.kind <= s_tuser;
      item.rx_byte <= s_tdata;
    end
  end

endmodule

[sv/lcfd_core.sv]
// Deframer state machine, running CRC, idle counter and result register.
module lcfd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  lcfd_pkg::in_item_t            item,
  output logic                          advance,
  input  logic [lcfd_pkg::LEN_W-1:0]    max_payload_len,
  input  logic [lcfd_pkg::IDLE_W-1:0]   idle_timeout_ticks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lcfd_pkg::result_t             result
);
  import lcfd_pkg::*;

  localparam logic [2:0] PH_LEN0 = 3'd0;
  localparam logic [2:0] PH_LEN1 = 3'd1;
  localparam logic [2:0] PH_PAY  = 3'd2;
  localparam logic [2:0] PH_CRC0 = 3'd3;
  localparam logic [2:0] PH_CRC1 = 3'd4;

  logic [2:0]        phase, phase_next;
  logic [7:0]        length_low_byte, length_low_byte_next;
  logic [LEN_W-1:0]  expected_length, expected_length_next;
  logic [LEN_W-1:0]  bytes_received, bytes_received_next;
  logic [CRC_W-1:0]  running_crc, running_crc_next;
  logic [7:0]        crc_low_byte, crc_low_byte_next;
  logic [IDLE_W-1:0] idle_count, idle_count_next;
  logic              emit;
  result_t           result_next;

  logic [IDLE_W-1:0] idle_inc;
  logic [15:0]       len_word;
  logic [LEN_W-1:0]  len_limit;
  logic              len_bad;

  assign advance = item_valid && (!out_valid || out_ready);

  assign idle_inc = (idle_count == IDLE_MAX) ? idle_count : idle_count + 16'd1;
  assign len_word = {item.rx_byte, length_low_byte};
  assign len_limit = (max_payload_len > MAX_LEN_LIMIT) ? MAX_LEN_LIMIT : max_payload_len;
  assign len_bad = (len_word == 16'd0) || (len_word > {7'd0, len_limit});

  always_comb begin
    phase_next = phase;
    length_low_byte_next = length_low_byte;
    expected_length_next = expected_length;
    bytes_received_next = bytes_received;
    running_crc_next = running_crc;
    crc_low_byte_next = crc_low_byte;
    idle_count_next = idle_count;
    emit = 1'b0;
    result_next = '0;

    if (item.kind == KIND_TICK) begin
      idle_count_next = idle_inc;
      if (phase != PH_LEN0 && idle_inc >= idle_timeout_ticks) begin
        phase_next = PH_LEN0;
        emit = 1'b1;
        result_next.status = ST_ABORT;
        result_next.frame_end = 1'b1;
        // length not known yet when only its low byte arrived
        result_next.frame_length = (phase == PH_LEN1) ? '0 : expected_length;
      end
    end else begin
      idle_count_next = '0;
      unique case (phase)
        PH_LEN0: begin
          length_low_byte_next = item.rx_byte;
          phase_next = PH_LEN1;
        end
        PH_LEN1: begin
          if (len_bad) begin
            phase_next = PH_LEN0;
          end else begin
            expected_length_next = len_word[LEN_W-1:0];
            bytes_received_next = '0;
            running_crc_next = CRC_INIT;
            phase_next = PH_PAY;
          end
        end
        PH_PAY: begin
          running_crc_next = crc_update(running_crc, item.rx_byte);
          bytes_received_next = bytes_received + 9'd1;
          if (bytes_received_next >= expected_length) begin
            phase_next = PH_CRC0;
          end
          emit = 1'b1;
          result_next.out_byte = item.rx_byte;
          result_next.status = ST_PAYLOAD;
        end
        PH_CRC0: begin
          crc_low_byte_next = item.rx_byte;
          phase_next = PH_CRC1;
        end
        PH_CRC1: begin
          phase_next = PH_LEN0;
          emit = 1'b1;
          result_next.status = ({item.rx_byte, crc_low_byte} == running_crc) ?
                               ST_CRC_GOOD : ST_CRC_BAD;
          result_next.frame_end = 1'b1;
          result_next.frame_length = expected_length;
        end
        default: begin
          phase_next = PH_LEN0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEN0;
      length_low_byte <= '0;
      expected_length <= '0;
      bytes_received <= '0;
      running_crc <= CRC_INIT;
      crc_low_byte <= '0;
      idle_count <= '0;
    end else if (advance) begin
      phase <= phase_next;
      length_low_byte <= length_low_byte_next;
      expected_length <= expected_length_next;
      bytes_received <= bytes_received_next;
      running_crc <= running_crc_next;
      crc_low_byte <= crc_low_byte_next;
      idle_count <= idle_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result <= result_next;
    end
  end

endmodule

[sv/length_crc_frame_deframer.sv]
// Top level of the length-prefixed CRC-16 frame deframer.
//
//  channel   direction  handshake             payload
//  s_axis    in         s_tvalid / s_tready   tdata rx_byte, tuser kind
//  m_axis    out        m_tvalid / m_tready   tdata out_byte+frame_length, tuser status,
//                                             tlast frame_end
//  cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while the output is not stalled: the input register holds an
// accepted item, then the FSM and the unrolled 8-bit CRC update settle any result
// it yields into the result register; result valid is registered with it.
// Reset is synchronous; it returns the FSM to waiting for a length byte and the
// registers to max length 256 and timeout 20 ticks.
// A stalled output holds its result; the input keeps accepting while the
// output register is free or being drained in the same cycle.
module length_crc_frame_deframer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
  input  logic                              s_tuser,   // [0] kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lcfd_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [16:8] frame_length
  output logic [1:0]                        m_tuser,   // [1:0] status
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [lcfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lcfd_pkg::*;

  logic              item_valid;
  in_item_t          item;
  logic              advance;
  result_t           result;
  logic [LEN_W-1:0]  max_payload_len;
  logic [IDLE_W-1:0] idle_timeout_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_LEN_RESET;
      idle_timeout_ticks <= IDLE_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_LEN:      max_payload_len <= cfg_data[LEN_W-1:0];
        REG_IDLE_TIMEOUT: idle_timeout_ticks <= cfg_data[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  lcfd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lcfd_core u_core (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (item_valid),
    .item               (item),
    .advance            (advance),
    .max_payload_len    (max_payload_len),
    .idle_timeout_ticks (idle_timeout_ticks),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .result             (result)
  );

  assign m_tdata = {{(OUT_TDATA_W - 8 - LEN_W){1'b0}}, result.frame_length, result.out_byte};
  assign m_tuser = result.status;
  assign m_tlast = result.frame_end;

  // verdicts and payload bytes never mix their markings
  a_verdict_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != ST_PAYLOAD)))
    else $error("frame_end does not match status");

  a_payload_no_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (result.frame_length == '0))
    else $error("payload item carries a length");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result.frame_length <= MAX_LEN_LIMIT))
    else $error("frame length above limit");

  // an empty result register always leaves room for a new item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule
